// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define S5_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("scanner assertion failed: implication");
`define S5_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
		else $error("scanner assertion failed: forbidden condition");
`else
`define S5_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define S5_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- hdl/s5scan_pkg.sv -----
// Package: constants, types and byte codes of the _S5_ scanner.
package s5scan_pkg;

	localparam int WINDOW_DEPTH = 16;
	localparam int WIN_IDX_W    = $clog2(WINDOW_DEPTH);
	localparam int SEEN_W       = $clog2(WINDOW_DEPTH + 1);
	localparam int LAG          = 13;
	localparam int FIRST_K      = 5;
	localparam int MIN_BODY     = 9;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_US       = 8'h5F;
	localparam logic [7:0] CH_S        = 8'h53;
	localparam logic [7:0] CH_5        = 8'h35;
	localparam logic [7:0] CH_ROOT     = 8'h5C;
	localparam logic [7:0] OP_NAME     = 8'h08;
	localparam logic [7:0] OP_PACKAGE  = 8'h12;
	localparam logic [7:0] OP_BYTE     = 8'h0A;
	localparam logic [7:0] PKGLEN_MASK = 8'hC0;

	typedef logic [WINDOW_DEPTH-1:0][7:0] window_t;

	typedef struct packed {
		logic       found;
		logic [7:0] sleep_type_a;
		logic [7:0] sleep_type_b;
	} res_t;

	typedef struct packed {
		logic push;
		res_t res;
	} push_t;

endpackage

// ----- hdl/s5scan_if.sv -----
// Channel interfaces: table body bytes in, scan results out.
interface s5scan_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_body;

	modport source (output valid, data_byte, end_of_body, input ready);
	modport sink (input valid, data_byte, end_of_body, output ready);
endinterface

interface s5scan_out_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [7:0] sleep_type_a;
	logic [7:0] sleep_type_b;

	modport source (output valid, found, sleep_type_a, sleep_type_b, input ready);
	modport sink (input valid, found, sleep_type_a, sleep_type_b, output ready);
endinterface

// ----- hdl/s5scan_front.sv -----
// Front end: byte window, candidate judging and result classification.
module s5scan_front (
	input  logic                 clk,
	input  logic                 arst_n,
	s5scan_in_if.sink            body,
	input  logic                 q_full,
	output s5scan_pkg::push_t    q_push
);
	import s5scan_pkg::*;

	typedef struct packed {
		logic       hit;
		logic [7:0] va;
		logic [7:0] vb;
	} judge_t;

	function automatic logic [7:0] at(window_t w, int idx);
		logic [7:0] b;
		b = '0;
		if (idx >= 0 && idx < WINDOW_DEPTH) begin
			b = w[idx[WIN_IDX_W-1:0]];
		end
		return b;
	endfunction

	function automatic judge_t judge(window_t w, logic [SEEN_W-1:0] seen, int k);
		judge_t     r;
		int         s;
		int         vi;
		logic [7:0] lenb;
		logic       pre;
		r    = '0;
		s    = int'(seen);
		lenb = at(w, k - 5) & PKGLEN_MASK;
		pre  = (k + 1 < s && at(w, k + 1) == OP_NAME) ||
			(k + 2 < s && at(w, k + 2) == OP_NAME && at(w, k + 1) == CH_ROOT);
		if (k >= FIRST_K && k < s && pre &&
			at(w, k) == CH_US && at(w, k - 1) == CH_S &&
			at(w, k - 2) == CH_5 && at(w, k - 3) == CH_US &&
			at(w, k - 4) == OP_PACKAGE) begin
			vi = k - 7 - int'(lenb[7:6]);
			if (vi >= 1) begin
				if (at(w, vi) == OP_BYTE) begin
					vi = vi - 1;
				end
				r.va = at(w, vi);
				vi   = vi - 1;
				if (vi >= 0) begin
					if (at(w, vi) == OP_BYTE) begin
						vi = vi - 1;
					end
					if (vi >= 0) begin
						r.hit = 1'b1;
						r.vb  = at(w, vi);
					end
				end
			end
		end
		return r;
	endfunction

	window_t           win_q;
	window_t           win_next;
	logic [SEEN_W-1:0] seen_q;
	logic [SEEN_W-1:0] seen_next;
	logic              reported_q;
	logic              accept;
	judge_t            jdg [FIRST_K:LAG];
	judge_t            sel;

	assign body.ready = !q_full;
	assign accept     = body.valid && body.ready;
	assign win_next   = {win_q[WINDOW_DEPTH-2:0], body.data_byte};
	assign seen_next  = (seen_q < SEEN_W'(WINDOW_DEPTH)) ? seen_q + 1'b1 : seen_q;

	for (genvar k = FIRST_K; k <= LAG; k++) begin : g_judge
		assign jdg[k] = judge(win_next, seen_next, k);
	end

	always_comb begin
		sel = '0;
		if (!body.end_of_body) begin
			sel = jdg[LAG];
		end else if (seen_next >= SEEN_W'(MIN_BODY)) begin
			for (int k = FIRST_K; k <= LAG; k++) begin
				if (jdg[k].hit) begin
					sel = jdg[k];
				end
			end
		end
	end

	assign q_push.push             = accept && !reported_q && (sel.hit || body.end_of_body);
	assign q_push.res.found        = sel.hit;
	assign q_push.res.sleep_type_a = sel.hit ? sel.va : 8'h00;
	assign q_push.res.sleep_type_b = sel.hit ? sel.vb : 8'h00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q      <= '0;
			seen_q     <= '0;
			reported_q <= 1'b0;
		end else if (accept) begin
			if (body.end_of_body) begin
				win_q      <= '0;
				seen_q     <= '0;
				reported_q <= 1'b0;
			end else begin
				win_q      <= win_next;
				seen_q     <= seen_next;
				reported_q <= reported_q || (q_push.push && sel.hit);
			end
		end
	end

endmodule

// ----- hdl/s5scan_queue.sv -----
// Short result queue between the front end and the output stage.
module s5scan_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  s5scan_pkg::push_t    q_push,
	input  logic                 pop,
	output s5scan_pkg::res_t     head,
	output logic                 empty,
	output logic                 full
);
	import s5scan_pkg::*;

	res_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	function automatic logic [QPTR_W-1:0] bump(logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] n;
		n = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
		return n;
	endfunction

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (q_push.push) begin
			mem_q[wr_q] <= q_push.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (q_push.push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (q_push.push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !q_push.push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/s5scan_back.sv -----
// Back end: output register that presents results to the sink.
module s5scan_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  s5scan_pkg::res_t     head,
	input  logic                 empty,
	output logic                 pop,
	s5scan_out_if.source         result
);
	import s5scan_pkg::*;

	logic valid_q;
	res_t data_q;

	assign pop = !empty && (!valid_q || result.ready);

	assign result.valid        = valid_q;
	assign result.found        = data_q.found;
	assign result.sleep_type_a = data_q.sleep_type_a;
	assign result.sleep_type_b = data_q.sleep_type_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= head;
		end
	end

endmodule

// ----- hdl/aml_s5_package_scanner.sv -----
// Top level of the _S5_ package scanner.
//   port    | dir | word
//   body    | in  | data_byte[7:0], end_of_body
//   result  | out | found, sleep_type_a[7:0], sleep_type_b[7:0]
// One byte is taken per cycle while body.ready is high; a byte is judged in the cycle it is accepted.
// A result passes through the result queue and then the output register before it reaches the result port.
// body.ready drops only while the two-entry result queue is full.
// arst_n clears the byte window, the byte count, the queue and the output stage.
// The final byte of a body returns the window and count to their reset values.
`include "assert_macros.svh"

module aml_s5_package_scanner (
	input  logic          clk,
	input  logic          arst_n,
	s5scan_in_if.sink     body,
	s5scan_out_if.source  result
);
	import s5scan_pkg::*;

	push_t q_push;
	res_t  q_head;
	logic  q_empty;
	logic  q_full;
	logic  pop;
	logic  res_zero;

	s5scan_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.body   (body),
		.q_full (q_full),
		.q_push (q_push)
	);

	s5scan_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.pop    (pop),
		.head   (q_head),
		.empty  (q_empty),
		.full   (q_full)
	);

	s5scan_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.empty  (q_empty),
		.pop    (pop),
		.result (result)
	);

	assign res_zero = (result.sleep_type_a == 8'h00) && (result.sleep_type_b == 8'h00);

	`S5_ASSERT_NEVER(a_queue_no_overflow, clk, arst_n, q_push.push && q_full)
	`S5_ASSERT_IMPLY(a_pop_has_data, clk, arst_n, pop, !q_empty)
	`S5_ASSERT_IMPLY(a_notfound_zero, clk, arst_n, result.valid && !result.found, res_zero)

endmodule
